>>> rtl/core/gtl_pkg.sv
// Shared types, codes and the letter table of the Greek to Latin transliterator.
`timescale 1ns / 1ps
`default_nettype none

package gtl_pkg;

  // ISO-8859-7 codes with special handling
  localparam logic [7:0] CODE_MU_UP  = 8'd204;
  localparam logic [7:0] CODE_NU_UP  = 8'd205;
  localparam logic [7:0] CODE_MU_LO  = 8'd236;
  localparam logic [7:0] CODE_NU_LO  = 8'd237;
  localparam logic [7:0] CODE_PI_UP  = 8'd208;
  localparam logic [7:0] CODE_PI_LO  = 8'd240;
  localparam logic [7:0] CODE_TAU_UP = 8'd212;
  localparam logic [7:0] CODE_TAU_LO = 8'd244;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;

  localparam int RUN_BYTES     = 4;
  localparam int RUN_CNT_W     = 3;
  localparam int RUN_IDX_W     = 2;
  localparam int QUEUE_DEPTH_D = 2;

  typedef enum logic [2:0] {
    NASAL_NONE  = 3'd0,
    NASAL_MU_LO = 3'd1,
    NASAL_MU_UP = 3'd2,
    NASAL_NU_LO = 3'd3,
    NASAL_NU_UP = 3'd4
  } nasal_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } xlat_t;

  // One input's worth of output bytes, emitted bytes[0] first
  typedef struct packed {
    logic [RUN_BYTES-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]      cnt;
  } run_t;

  function automatic xlat_t x1(input logic [7:0] a);
    xlat_t r;
    r.len = 2'd1;
    r.b0  = a;
    r.b1  = 8'd0;
    r.b2  = 8'd0;
    return r;
  endfunction

  function automatic xlat_t x2(input logic [7:0] a, input logic [7:0] b);
    xlat_t r;
    r.len = 2'd2;
    r.b0  = a;
    r.b1  = b;
    r.b2  = 8'd0;
    return r;
  endfunction

  function automatic xlat_t x3(input logic [7:0] a, input logic [7:0] b,
                               input logic [7:0] c);
    xlat_t r;
    r.len = 2'd3;
    r.b0  = a;
    r.b1  = b;
    r.b2  = c;
    return r;
  endfunction

  // Latin spelling of a byte of 32 or more; unmapped bytes map to themselves
  function automatic xlat_t xlat(input logic [7:0] c);
    xlat_t r;
    unique case (c)
      8'd193: r = x1("A");
      8'd194: r = x1("V");
      8'd195: r = x1("G");
      8'd196: r = x1("D");
      8'd197: r = x1("E");
      8'd198: r = x1("Z");
      8'd199: r = x1("H");
      8'd200: r = x1("8");
      8'd201: r = x1("I");
      8'd202: r = x1("K");
      8'd203: r = x1("L");
      8'd204: r = x1("M");
      8'd205: r = x1("N");
      8'd206: r = x2("K", "S");
      8'd207: r = x1("O");
      8'd208: r = x1("P");
      8'd209: r = x1("R");
      8'd211: r = x1("S");
      8'd212: r = x1("T");
      8'd213: r = x1("Y");
      8'd214: r = x1("F");
      8'd215: r = x1("X");
      8'd216: r = x2("P", "S");
      8'd217: r = x1("W");
      8'd225: r = x1("a");
      8'd226: r = x1("v");
      8'd227: r = x1("g");
      8'd228: r = x1("d");
      8'd229: r = x1("e");
      8'd230: r = x1("z");
      8'd231: r = x1("h");
      8'd232: r = x1("8");
      8'd233: r = x1("i");
      8'd234: r = x1("k");
      8'd235: r = x1("l");
      8'd236: r = x1("m");
      8'd237: r = x1("n");
      8'd238: r = x2("k", "s");
      8'd239: r = x1("o");
      8'd240: r = x1("p");
      8'd241: r = x1("r");
      8'd242: r = x1("s");
      8'd243: r = x1("s");
      8'd244: r = x1("t");
      8'd245: r = x1("y");
      8'd246: r = x1("f");
      8'd247: r = x1("x");
      8'd248: r = x2("p", "s");
      8'd249: r = x1("w");
      8'd182: r = x2("'", "A");
      8'd184: r = x2("'", "E");
      8'd185: r = x2("'", "H");
      8'd186: r = x2("'", "I");
      8'd188: r = x2("'", "O");
      8'd191: r = x2("'", "W");
      8'd190: r = x2("'", "Y");
      8'd220: r = x2("a", "'");
      8'd221: r = x2("e", "'");
      8'd222: r = x2("h", "'");
      8'd223: r = x2("i", "'");
      8'd252: r = x2("o", "'");
      8'd254: r = x2("w", "'");
      8'd253: r = x2("y", "'");
      8'd250: r = x2("i", "\"");
      8'd251: r = x2("y", "\"");
      8'd192: r = x3("i", "'", "\"");
      8'd224: r = x3("y", "'", "\"");
      default: r = x1(c);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/greek_to_latin_transliterator_unit.sv
// Top level of the ISO-8859-7 Greek to Latin transliterator.
// Each run is registered in the queue, then in the emitter, before its first byte is offered.
// Throughput: the emitter sends one byte per cycle while out_ready is high; an input yields
// 0 to 4 bytes; the input side takes a byte every cycle while the run queue has room.
// Reset: synchronous active-low rst_n clears the held nasal, the queue and the emitter.
`timescale 1ns / 1ps
`default_nettype none

module greek_to_latin_transliterator_unit #(
  parameter int QUEUE_DEPTH = gtl_pkg::QUEUE_DEPTH_D
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);
  import gtl_pkg::*;

  // front end -> queue
  logic q_push;
  run_t push_run;
  logic q_not_full;
  // queue -> emitter
  logic q_pop;
  logic q_not_empty;
  run_t head_run;

  // classify each byte, resolve the held nasal, build the run of bytes
  gtl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_ready  (q_not_full),
    .q_push   (q_push),
    .q_run    (push_run)
  );

  // decouples input transfers from a stalled output
  gtl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_run  (push_run),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_run  (head_run)
  );

  // one byte per output transfer; last flag on the run's final byte
  gtl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_not_empty),
    .q_run           (head_run),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // never write a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_not_full)
    else $error("run queue overflow");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("run queue underflow");

  // a control byte always yields a run of its own
  a_ctrl_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_byte < CTRL_LIMIT)) |-> q_push)
    else $error("control byte produced no run");

  // a run pushed into an empty queue with the emitter idle is popped at the next
  // edge, so its first byte is offered the cycle after that
  a_emit_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !out_valid && !q_not_empty) |=> ##1 out_valid)
    else $error("emitter did not pick up queued run");

endmodule

`default_nettype wire

>>> rtl/core/gtl_front.sv
// Front end: takes input bytes, tracks the held nasal and builds output runs.
`timescale 1ns / 1ps
`default_nettype none

module gtl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          q_ready,
  output logic               q_push,
  output gtl_pkg::run_t      q_run
);
  import gtl_pkg::*;

  nasal_t pending_r, pending_nxt;
  nasal_t new_p;
  xlat_t  map;
  xlat_t  buf_x;
  logic   accept;
  logic   ctrl;
  logic   has_p;
  logic   labial;
  logic   stop;
  logic   lead;
  logic [7:0] plain_ch;
  logic [7:0] merged_ch;
  logic [RUN_CNT_W-1:0] buf_cnt;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign ctrl     = in_byte < CTRL_LIMIT;
  assign map      = xlat(in_byte);

  always_comb begin
    unique case (pending_r)
      NASAL_MU_LO: begin plain_ch = "m"; merged_ch = "b"; end
      NASAL_MU_UP: begin plain_ch = "M"; merged_ch = "B"; end
      NASAL_NU_LO: begin plain_ch = "n"; merged_ch = "d"; end
      NASAL_NU_UP: begin plain_ch = "N"; merged_ch = "D"; end
      default:     begin plain_ch = 8'd0; merged_ch = 8'd0; end
    endcase
  end

  always_comb begin
    unique case (in_byte)
      CODE_MU_LO: new_p = NASAL_MU_LO;
      CODE_MU_UP: new_p = NASAL_MU_UP;
      CODE_NU_LO: new_p = NASAL_NU_LO;
      CODE_NU_UP: new_p = NASAL_NU_UP;
      default:    new_p = NASAL_NONE;
    endcase
  end

  assign has_p  = pending_r != NASAL_NONE;
  assign labial = pending_r == NASAL_MU_LO || pending_r == NASAL_MU_UP;
  assign stop   = labial ? (in_byte == CODE_PI_UP || in_byte == CODE_PI_LO)
                         : (in_byte == CODE_TAU_UP || in_byte == CODE_TAU_LO);
  assign lead   = has_p && !stop;
  // nasal followed by its stop collapses to one merged letter
  assign buf_x  = (has_p && stop) ? x1(merged_ch) : map;
  assign buf_cnt = (new_p == NASAL_NONE) ? RUN_CNT_W'(buf_x.len) : '0;

  always_comb begin
    q_run = '0;
    if (ctrl) begin
      q_run.bytes[0] = in_byte;
      q_run.cnt      = RUN_CNT_W'(1);
    end else if (lead) begin
      q_run.bytes[0] = plain_ch;
      q_run.bytes[1] = buf_x.b0;
      q_run.bytes[2] = buf_x.b1;
      q_run.bytes[3] = buf_x.b2;
      q_run.cnt      = buf_cnt + RUN_CNT_W'(1);
    end else begin
      q_run.bytes[0] = buf_x.b0;
      q_run.bytes[1] = buf_x.b1;
      q_run.bytes[2] = buf_x.b2;
      q_run.cnt      = buf_cnt;
    end
  end

  // runs with no bytes (nasal held) never enter the queue
  assign q_push = accept && (q_run.cnt != '0);

  always_comb begin
    pending_nxt = pending_r;
    if (accept && !ctrl) begin
      pending_nxt = new_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= NASAL_NONE;
    end else begin
      pending_r <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gtl_queue.sv
// Short run queue between front end and emitter.
`timescale 1ns / 1ps
`default_nettype none

module gtl_queue #(
  parameter int DEPTH = gtl_pkg::QUEUE_DEPTH_D
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gtl_pkg::run_t push_run,
  output logic               not_full,
  input  wire logic          pop,
  output logic               not_empty,
  output gtl_pkg::run_t      head_run
);
  import gtl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign not_full  = fill_r != CNT_W'(DEPTH);
  assign not_empty = fill_r != '0;
  assign head_run  = store[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gtl_back.sv
// Emitter: plays out one run a byte per cycle while out_ready is high, flagging its final byte.
`timescale 1ns / 1ps
`default_nettype none

module gtl_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire gtl_pkg::run_t q_run,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run
);
  import gtl_pkg::*;

  run_t                 cur_r, cur_nxt;
  logic                 act_r, act_nxt;
  logic [RUN_IDX_W-1:0] idx_r, idx_nxt;
  logic                 last;
  logic                 xfer;

  assign last            = (RUN_CNT_W'(idx_r) + RUN_CNT_W'(1)) == cur_r.cnt;
  assign xfer            = act_r && out_ready;
  assign out_valid       = act_r;
  assign out_byte        = cur_r.bytes[idx_r];
  assign out_last_of_run = last;
  assign q_pop           = q_valid && (!act_r || (xfer && last));

  always_comb begin
    cur_nxt = cur_r;
    act_nxt = act_r;
    idx_nxt = idx_r;
    if (q_pop) begin
      cur_nxt = q_run;
      act_nxt = 1'b1;
      idx_nxt = '0;
    end else if (xfer) begin
      if (last) begin
        act_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + RUN_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
    end else begin
      act_r <= act_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire
